/* rtl/core/escape_sequence_decoder_defines.svh */
// Assertion macros used by the checker file.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Clocked assertion, muted while reset is asserted.
`define ESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ESD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg
// Types and character codes for the escape sequence decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_e;

  // Source characters
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // Decoded control codes
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FS  = 8'h1C;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } res_t;

  // Up to two results for one input word
  typedef struct packed {
    logic [1:0]     count;
    res_t [1:0]     res;
  } dec_out_t;

endpackage

`default_nettype wire

/* rtl/core/esd_if.sv */
// ----------------------------------------------------------------------------
// esd_in_if / esd_out_if
// Valid/ready channels for raw input words and decoded result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/esd_decode.sv */
// ----------------------------------------------------------------------------
// esd_decode
// Escape decode state and single-pass next-state / result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              commit_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              end_i,
  output esd_pkg::dec_out_t      dec_o
);
  import esd_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;

  logic       is_dec, is_oct, is_lhex, is_uhex, is_hex;
  logic [3:0] nib;
  logic [7:0] hex_acc, oct_acc;
  logic [1:0] cnt_inc;
  logic [1:0] n;
  logic [7:0] rb [2];
  logic       rv [2];

  assign is_dec  = (in_byte_i >= CH_0) && (in_byte_i <= CH_9);
  assign is_oct  = (in_byte_i >= CH_0) && (in_byte_i <= CH_7);
  assign is_lhex = (in_byte_i >= CH_LA) && (in_byte_i <= CH_LF);
  assign is_uhex = (in_byte_i >= CH_UA) && (in_byte_i <= CH_UF);
  assign is_hex  = is_dec || is_lhex || is_uhex;
  // letters: low nibble 1..6 maps to 10..15
  assign nib     = is_dec ? in_byte_i[3:0] : (in_byte_i[3:0] + 4'd9);
  assign hex_acc = {acc_q[3:0], nib};
  assign oct_acc = {acc_q[4:0], in_byte_i[2:0]};
  assign cnt_inc = cnt_q + 2'd1;

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    n      = 2'd0;
    rb[0]  = 8'h00;
    rb[1]  = 8'h00;
    rv[0]  = 1'b0;
    rv[1]  = 1'b0;

    case (mode_q)
      MODE_TEXT: begin
        if (in_byte_i == CH_BSL) begin
          mode_d = MODE_ESC;
        end else begin
          rb[0] = in_byte_i; rv[0] = 1'b1; n = 2'd1;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_TEXT;
        n      = 2'd1;
        rv[0]  = 1'b1;
        case (in_byte_i)
          CH_A:  rb[0] = CODE_BEL;
          CH_B:  rb[0] = CODE_BS;
          CH_C:  rb[0] = CODE_FS;
          CH_F:  rb[0] = CODE_FF;
          CH_N:  rb[0] = CODE_LF;
          CH_T:  rb[0] = CODE_HT;
          CH_R:  rb[0] = CODE_CR;
          CH_V:  rb[0] = CODE_VT;
          CH_QM: rb[0] = CH_QM;
          CH_NL: begin
            n = 2'd0; rv[0] = 1'b0;
          end
          CH_XL, CH_XU: begin
            n = 2'd0; rv[0] = 1'b0;
            mode_d = MODE_HEX; acc_d = 8'h00; cnt_d = 2'd0;
          end
          default: begin
            if (is_oct) begin
              n = 2'd0; rv[0] = 1'b0;
              mode_d = MODE_OCT; acc_d = {5'd0, in_byte_i[2:0]}; cnt_d = 2'd1;
            end else begin
              rb[0] = in_byte_i;
            end
          end
        endcase
      end
      MODE_HEX, MODE_OCT: begin
        if ((mode_q == MODE_HEX) ? is_hex : is_oct) begin
          acc_d = (mode_q == MODE_HEX) ? hex_acc : oct_acc;
          cnt_d = cnt_inc;
          if (cnt_inc >= ((mode_q == MODE_HEX) ? HEX_DIGITS : OCT_DIGITS)) begin
            rb[0] = acc_d; rv[0] = 1'b1; n = 2'd1;
            mode_d = MODE_TEXT;
          end
        end else begin
          // run ended early: flush the value, then treat the byte as text
          rb[0] = acc_q; rv[0] = 1'b1; n = 2'd1;
          mode_d = MODE_TEXT;
          if (in_byte_i == CH_BSL) begin
            mode_d = MODE_ESC;
          end else begin
            rb[1] = in_byte_i; rv[1] = 1'b1; n = 2'd2;
          end
        end
      end
      default: mode_d = MODE_TEXT;
    endcase

    if (end_i) begin
      // pending run can only follow a byte that produced nothing
      if (mode_d == MODE_HEX || mode_d == MODE_OCT) begin
        rb[0] = acc_d; rv[0] = 1'b1; n = 2'd1;
      end
      if (n == 2'd0) begin
        n = 2'd1;
      end
      mode_d = MODE_TEXT;
      acc_d  = 8'h00;
      cnt_d  = 2'd0;
    end
  end

  always_comb begin
    dec_o.count              = n;
    dec_o.res[0].out_byte    = rb[0];
    dec_o.res[0].byte_valid  = rv[0];
    dec_o.res[0].last        = end_i && (n == 2'd1);
    dec_o.res[1].out_byte    = rb[1];
    dec_o.res[1].byte_valid  = rv[1];
    dec_o.res[1].last        = end_i && (n == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      acc_q  <= 8'h00;
      cnt_q  <= 2'd0;
    end else if (commit_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/esd_res_fifo.sv */
// ----------------------------------------------------------------------------
// esd_res_fifo
// Result queue: takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_res_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    push_n_i,
  input  wire esd_pkg::res_t [1:0]           push_data_i,
  output logic                               room2_o,
  output logic                               pop_valid_o,
  input  wire logic                          pop_ready_i,
  output esd_pkg::res_t                      pop_data_o
);
  import esd_pkg::*;

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_1;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_1    = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(push_n_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_1] <= push_data_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/escape_sequence_decoder.sv */
// Path: an accepted word is held in the input register, then decoded into
//   the four-entry result queue, which offers its result words on out_o.
// Throughput: one input word per cycle while the queue has room for two
//   results; a word that yields two results leaves as two output words.
// Reset: rst_ni is asynchronous, active low; clears decode state, input
//   valid flag and queue. No clearing pass; ready right after reset.
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streams an escaped string one byte per word and emits decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  esd_in_if.sink     in_i,
  esd_out_if.source  out_o
);
  import esd_pkg::*;

  // Input register: one raw word waiting for decode
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  logic       room2;
  logic       commit;
  logic [1:0] push_n;
  dec_out_t   dec;
  res_t       head;

  // Decode fires when a word is held and the queue can take its worst case
  // of two results. The input side is free whenever the held word leaves.
  assign commit   = in_vld_q && room2;
  assign in_i.ready = !in_vld_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      in_end_q  <= in_i.end_of_string;
    end
  end

  // Escape state machine and result formation in a single pass
  esd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit),
    .in_byte_i (in_byte_q),
    .end_i     (in_end_q),
    .dec_o     (dec)
  );

  assign push_n = commit ? dec.count : 2'd0;

  // Result queue doubles as the output register stage
  esd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (dec.res),
    .room2_o     (room2),
    .pop_valid_o (out_o.valid),
    .pop_ready_i (out_o.ready),
    .pop_data_o  (head)
  );

  assign out_o.out_byte   = head.out_byte;
  assign out_o.byte_valid = head.byte_valid;
  assign out_o.last       = head.last;

endmodule

`default_nettype wire

/* rtl/core/esd_checker.sv */
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks on the decoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_sequence_decoder_defines.svh"

module esd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       byte_valid_i,
  input wire logic       last_i
);

  // Queue is empty while reset is held
  `ESD_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_i, "output valid during reset")

  // A stalled word stays offered
  `ESD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output dropped")

  // A byte-less word is only ever the end marker
  `ESD_ASSERT(a_empty_is_last, out_valid_i && !byte_valid_i |-> last_i, "empty word not last")

  // A byte-less end marker carries a zero byte
  `ESD_ASSERT(a_empty_zero, out_valid_i && !byte_valid_i |-> out_byte_i == 8'h00,
              "empty word has nonzero byte")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .byte_valid_i (out_o.byte_valid),
  .last_i       (out_o.last)
);

`default_nettype wire
